>>> sv/stepper_opto_calibration_macros.svh
// assertion macros for the stepper opto calibration checker
// no dependencies; taken in by the checker file
`ifndef STEPPER_OPTO_CALIBRATION_MACROS_SVH
`define STEPPER_OPTO_CALIBRATION_MACROS_SVH

// same-cycle implication, reset masks the check
`define SOPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sopc check failed");

// next-cycle implication, reset masks the check
`define SOPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sopc check failed");

`endif

>>> sv/sopc_pkg.sv
// shared types and constants for the stepper opto calibration block
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package sopc_pkg;

    localparam int unsigned CNT_W  = 16;
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    localparam logic [CNT_W-1:0] STEP_LIMIT_RST = 16'd8192;
    localparam logic [CNT_W-1:0] SLOT_LIMIT_RST = 16'd512;

    // register index taken from the word address
    localparam logic REG_STEP_LIMIT = 1'b0;
    localparam logic REG_SLOT_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        CMD_MEASURE = 2'd0,
        CMD_ALIGN   = 2'd1,
        CMD_REPORT  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_EDGE     = 2'd1,
        ST_STUCK_LOW   = 2'd2,
        ST_NO_SECOND   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_RISE = 3'd1,
        PH_FALL = 3'd2,
        PH_SLOT = 3'd3,
        PH_REV  = 3'd4,
        PH_HALF = 3'd5
    } t_phase;

    typedef enum logic {
        OP_MEASURE = 1'b0,
        OP_ALIGN   = 1'b1
    } t_op;

    typedef struct packed {
        logic [CNT_W-1:0] step_limit;
        logic [CNT_W-1:0] slot_limit;
    } t_cfg;

    typedef struct packed {
        logic             step_request;
        logic             motor_stop;
        logic             done_res;
        t_status          status;
        logic [CNT_W-1:0] revolution_steps;
        logic [CNT_W-1:0] slot_steps;
    } t_result;

endpackage

>>> sv/sopc_regs.sv
// apb configuration registers: step limit and slot step limit
// depends on sopc_pkg
`timescale 1ns / 1ps

module sopc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sopc_pkg::ADDR_W-1:0]  paddr,
    input  logic [sopc_pkg::DATA_W-1:0]  pwdata,
    output logic [sopc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output sopc_pkg::t_cfg               o_cfg
);

    logic [sopc_pkg::CNT_W-1:0] r_step_limit;
    logic [sopc_pkg::CNT_W-1:0] r_slot_limit;
    logic                       wr_en;
    logic                       reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit <= sopc_pkg::STEP_LIMIT_RST;
            r_slot_limit <= sopc_pkg::SLOT_LIMIT_RST;
        end else if (wr_en) begin
            if (reg_idx == sopc_pkg::REG_STEP_LIMIT) begin
                r_step_limit <= pwdata[sopc_pkg::CNT_W-1:0];
            end else begin
                r_slot_limit <= pwdata[sopc_pkg::CNT_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == sopc_pkg::REG_STEP_LIMIT) begin
            prdata[sopc_pkg::CNT_W-1:0] = r_step_limit;
        end else begin
            prdata[sopc_pkg::CNT_W-1:0] = r_slot_limit;
        end
    end

    assign o_cfg.step_limit = r_step_limit;
    assign o_cfg.slot_limit = r_slot_limit;

endmodule

>>> sv/sopc_core.sv
// calibration sequencer: phase and counter registers plus next-step logic
// depends on sopc_pkg
`timescale 1ns / 1ps

module sopc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_fire,
    input  logic [1:0]        i_cmd,
    input  logic              i_level,
    input  sopc_pkg::t_cfg    i_cfg,
    output logic              o_emit,
    output sopc_pkg::t_result o_res
);

    sopc_pkg::t_phase           r_phase,  n_phase;
    logic [sopc_pkg::CNT_W-1:0] r_search, n_search;
    logic [sopc_pkg::CNT_W-1:0] r_rot,    n_rot;
    logic [sopc_pkg::CNT_W-1:0] r_slot,   n_slot;
    logic                       r_edge,   n_edge;
    sopc_pkg::t_op              r_op,     n_op;

    logic [sopc_pkg::CNT_W-1:0] sc_inc;
    logic [sopc_pkg::CNT_W-1:0] rc_inc;
    logic [sopc_pkg::CNT_W-1:0] rev_cnt;
    sopc_pkg::t_phase           search_ph;
    logic                       go_edge;
    logic                       go_search;
    logic                       go_rev;
    logic                       go_fail;
    logic                       go_ask;
    logic                       go_done;

    assign sc_inc = r_search + sopc_pkg::CNT_W'(1);
    assign rc_inc = r_rot + sopc_pkg::CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= sopc_pkg::PH_IDLE;
            r_search <= '0;
            r_rot    <= '0;
            r_slot   <= '0;
            r_edge   <= 1'b0;
            r_op     <= sopc_pkg::OP_MEASURE;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_search <= n_search;
            r_rot    <= n_rot;
            r_slot   <= n_slot;
            r_edge   <= n_edge;
            r_op     <= n_op;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_search  = r_search;
        n_rot     = r_rot;
        n_slot    = r_slot;
        n_edge    = r_edge;
        n_op      = r_op;
        o_emit    = 1'b0;
        o_res     = '0;
        search_ph = sopc_pkg::PH_FALL;
        rev_cnt   = '0;
        go_edge   = 1'b0;
        go_search = 1'b0;
        go_rev    = 1'b0;
        go_fail   = 1'b0;
        go_ask    = 1'b0;
        go_done   = 1'b0;

        // first step: what the command or report asks for
        if (i_valid) begin
            case (i_cmd)
                sopc_pkg::CMD_MEASURE, sopc_pkg::CMD_ALIGN: begin
                    if (r_phase == sopc_pkg::PH_IDLE) begin
                        o_emit = 1'b1;
                        n_op   = (i_cmd == sopc_pkg::CMD_ALIGN) ? sopc_pkg::OP_ALIGN
                                                                : sopc_pkg::OP_MEASURE;
                        if (r_edge) begin
                            go_edge = 1'b1;
                        end else begin
                            go_search = 1'b1;
                            search_ph = i_level ? sopc_pkg::PH_FALL : sopc_pkg::PH_RISE;
                        end
                    end
                end
                sopc_pkg::CMD_REPORT: begin
                    case (r_phase)
                        sopc_pkg::PH_IDLE: begin
                            o_emit = 1'b0;
                        end
                        sopc_pkg::PH_RISE: begin
                            o_emit   = 1'b1;
                            n_search = sc_inc;
                            if (i_level) begin
                                go_search = 1'b1;
                                search_ph = sopc_pkg::PH_FALL;
                            end else if (sc_inc >= i_cfg.step_limit) begin
                                go_fail = 1'b1;
                            end else begin
                                go_ask = 1'b1;
                            end
                        end
                        sopc_pkg::PH_FALL: begin
                            o_emit   = 1'b1;
                            n_search = sc_inc;
                            if (!i_level) begin
                                go_edge = 1'b1;
                            end else if (sc_inc >= i_cfg.step_limit) begin
                                go_fail = 1'b1;
                            end else begin
                                go_ask = 1'b1;
                            end
                        end
                        sopc_pkg::PH_SLOT: begin
                            o_emit   = 1'b1;
                            n_search = sc_inc;
                            n_rot    = rc_inc;
                            if (i_level) begin
                                n_slot  = rc_inc;
                                go_rev  = 1'b1;
                                rev_cnt = rc_inc;
                            end else if (sc_inc >= i_cfg.slot_limit) begin
                                n_edge       = 1'b0;
                                go_done      = 1'b1;
                                o_res.status = sopc_pkg::ST_STUCK_LOW;
                            end else begin
                                go_ask = 1'b1;
                            end
                        end
                        sopc_pkg::PH_REV: begin
                            o_emit = 1'b1;
                            n_rot  = rc_inc;
                            if (!i_level) begin
                                n_edge                 = 1'b1;
                                go_done                = 1'b1;
                                o_res.revolution_steps = rc_inc;
                            end else begin
                                go_rev  = 1'b1;
                                rev_cnt = rc_inc;
                            end
                        end
                        sopc_pkg::PH_HALF: begin
                            o_emit   = 1'b1;
                            n_search = sc_inc;
                            if (sc_inc >= {1'b0, r_slot[sopc_pkg::CNT_W-1:1]}) begin
                                n_edge           = 1'b0;
                                go_done          = 1'b1;
                                o_res.motor_stop = 1'b1;
                            end else begin
                                go_ask = 1'b1;
                            end
                        end
                        default: begin
                            n_phase = sopc_pkg::PH_IDLE;
                        end
                    endcase
                end
                default: begin
                    o_emit = 1'b0;
                end
            endcase
        end

        // standing on the falling edge: slot count or half-slot move
        if (go_edge) begin
            n_edge = 1'b1;
            if (n_op == sopc_pkg::OP_MEASURE) begin
                n_rot    = '0;
                n_search = '0;
                if (i_cfg.slot_limit == '0) begin
                    n_slot  = '0;
                    go_rev  = 1'b1;
                    rev_cnt = '0;
                end else begin
                    n_phase = sopc_pkg::PH_SLOT;
                    go_ask  = 1'b1;
                end
            end else begin
                n_search = '0;
                if (r_slot[sopc_pkg::CNT_W-1:1] == '0) begin
                    n_edge           = 1'b0;
                    go_done          = 1'b1;
                    o_res.motor_stop = 1'b1;
                end else begin
                    n_phase = sopc_pkg::PH_HALF;
                    go_ask  = 1'b1;
                end
            end
        end

        if (go_search) begin
            n_phase  = search_ph;
            n_search = '0;
            if (i_cfg.step_limit == '0) begin
                go_fail = 1'b1;
            end else begin
                go_ask = 1'b1;
            end
        end

        if (go_rev) begin
            n_phase = sopc_pkg::PH_REV;
            if (rev_cnt >= i_cfg.step_limit) begin
                n_edge       = 1'b0;
                go_done      = 1'b1;
                o_res.status = sopc_pkg::ST_NO_SECOND;
            end else begin
                go_ask = 1'b1;
            end
        end

        if (go_fail) begin
            go_done          = 1'b1;
            o_res.status     = sopc_pkg::ST_NO_EDGE;
            o_res.motor_stop = (n_op == sopc_pkg::OP_ALIGN);
        end

        if (go_done) begin
            n_phase = sopc_pkg::PH_IDLE;
        end

        o_res.step_request = go_ask;
        o_res.done_res     = go_done;
        o_res.slot_steps   = n_slot;
    end

endmodule

>>> sv/stepper_opto_calibration.sv
// channel        direction  handshake                  payload
// item in        input      i_in_valid / o_in_ready    i_command, i_sensor_level
// result out     output     o_out_valid / i_out_ready  o_step_request .. o_slot_steps
// config         input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// one transaction per cycle unless results stall; a result is registered as its
// item fires; rate is set by the input register -> sequencer -> result register path
// reset is synchronous, active low; limits return to 8192 and 512 steps
// a stalled result holds the result register; the input register still drains
// transactions that give no result, and takes a new one as it drains
`timescale 1ns / 1ps

module stepper_opto_calibration (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_command,
    input  logic                         i_sensor_level,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_step_request,
    output logic                         o_motor_stop,
    output logic                         o_done_res,
    output logic [1:0]                   o_status,
    output logic [15:0]                  o_revolution_steps,
    output logic [15:0]                  o_slot_steps,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sopc_pkg::ADDR_W-1:0]  paddr,
    input  logic [sopc_pkg::DATA_W-1:0]  pwdata,
    output logic [sopc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    sopc_pkg::t_cfg    cfg;
    sopc_pkg::t_result core_res;
    sopc_pkg::t_result r_out;
    logic              r_out_valid;
    logic              r_in_valid;
    logic [1:0]        r_in_cmd;
    logic              r_in_level;
    logic              core_emit;
    logic              out_free;
    logic              fire;

    sopc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sopc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_fire  (fire),
        .i_cmd   (r_in_cmd),
        .i_level (r_in_level),
        .i_cfg   (cfg),
        .o_emit  (core_emit),
        .o_res   (core_res)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    // ignored transactions drain even while the result register is full
    assign fire       = r_in_valid && (!core_emit || out_free);
    assign o_in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_cmd   <= i_command;
            r_in_level <= i_sensor_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && core_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && core_emit) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_step_request     = r_out.step_request;
    assign o_motor_stop       = r_out.motor_stop;
    assign o_done_res         = r_out.done_res;
    assign o_status           = r_out.status;
    assign o_revolution_steps = r_out.revolution_steps;
    assign o_slot_steps       = r_out.slot_steps;

endmodule

>>> sv/sopc_checker.sv
// port-level checks on the result channel of the calibration block
// depends on stepper_opto_calibration_macros.svh, sopc_pkg; bound to top below
`timescale 1ns / 1ps
`include "stepper_opto_calibration_macros.svh"

module sopc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_step_request,
    input logic        o_motor_stop,
    input logic        o_done_res,
    input logic [1:0]  o_status,
    input logic [15:0] o_revolution_steps,
    input logic [15:0] o_slot_steps
);

    // a stalled result stays valid and keeps its payload but for the stop flag
    `SOPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_step_request) && $stable(o_done_res)
        && $stable(o_status) && $stable(o_revolution_steps) && $stable(o_slot_steps))

    // every result either asks for a step or finishes, never both
    `SOPC_ASSERT_NOW(a_step_xor_done, i_clk, i_rst_n, o_out_valid,
        o_step_request ^ o_done_res)

    // a step request carries no status, count or stop
    `SOPC_ASSERT_NOW(a_step_clean, i_clk, i_rst_n, o_out_valid && o_step_request,
        o_status == sopc_pkg::ST_OK && o_revolution_steps == 16'd0 && !o_motor_stop)

    // an error finish reports no revolution count
    `SOPC_ASSERT_NOW(a_err_no_count, i_clk, i_rst_n,
        o_out_valid && o_status != sopc_pkg::ST_OK, o_revolution_steps == 16'd0)

endmodule

bind stepper_opto_calibration sopc_checker u_sopc_checker (.*);

>>> sim/tb_top.sv
// testbench for the stepper opto calibration sequencer: directed and random runs
// every result transaction is checked against a cycle-free predictor of the sequencer
// depends on sopc_pkg and the stepper_opto_calibration top level
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0]  CMD_UNUSED        = 2'd3;
    localparam int          DIRECTED_N        = 25;
    localparam int          NUM_SETTINGS      = 10;
    localparam int unsigned ITEMS_PER_SETTING = 120;
    localparam int unsigned LIMIT_CYCLES      = 500000;
    localparam int unsigned HOLD_OFF_CYCLES   = 80;

    // predicts the sequencer and keeps the results still owed by the block
    class calib_scoreboard;
        sopc_pkg::t_result pending[$];
        logic [15:0]       step_lim   = sopc_pkg::STEP_LIMIT_RST;
        logic [15:0]       slot_lim   = sopc_pkg::SLOT_LIMIT_RST;
        sopc_pkg::t_phase  phase      = sopc_pkg::PH_IDLE;
        logic [15:0]       search_cnt = '0;
        logic [15:0]       rot_cnt    = '0;
        logic [15:0]       slot_len   = '0;
        logic              on_edge    = 1'b0;
        sopc_pkg::t_op     op         = sopc_pkg::OP_MEASURE;
        int unsigned       errors     = 0;

        function void set_limit(logic idx, logic [15:0] val);
            if (idx == sopc_pkg::REG_STEP_LIMIT) begin
                step_lim = val;
            end else begin
                slot_lim = val;
            end
        endfunction

        function bit busy();
            return phase != sopc_pkg::PH_IDLE;
        endfunction

        function void push_result(logic step, logic stop, logic done,
                                  sopc_pkg::t_status st, logic [15:0] rev);
            sopc_pkg::t_result r;
            r.step_request     = step;
            r.motor_stop       = stop;
            r.done_res         = done;
            r.status           = st;
            r.revolution_steps = rev;
            r.slot_steps       = slot_len;
            pending.push_back(r);
        endfunction

        function void ask_step();
            push_result(1'b1, 1'b0, 1'b0, sopc_pkg::ST_OK, 16'd0);
        endfunction

        function void finish_op(logic stop, sopc_pkg::t_status st, logic [15:0] rev);
            phase = sopc_pkg::PH_IDLE;
            push_result(1'b0, stop, 1'b1, st, rev);
        endfunction

        function void search_fail();
            finish_op(op == sopc_pkg::OP_ALIGN, sopc_pkg::ST_NO_EDGE, 16'd0);
        endfunction

        function void start_rev();
            phase = sopc_pkg::PH_REV;
            if (rot_cnt >= step_lim) begin
                on_edge = 1'b0;
                finish_op(1'b0, sopc_pkg::ST_NO_SECOND, 16'd0);
            end else begin
                ask_step();
            end
        endfunction

        function void start_slot();
            rot_cnt    = '0;
            search_cnt = '0;
            if (slot_lim == 16'd0) begin
                slot_len = '0;
                start_rev();
            end else begin
                phase = sopc_pkg::PH_SLOT;
                ask_step();
            end
        endfunction

        function void start_half();
            search_cnt = '0;
            if ((slot_len >> 1) == 16'd0) begin
                on_edge = 1'b0;
                finish_op(1'b1, sopc_pkg::ST_OK, 16'd0);
            end else begin
                phase = sopc_pkg::PH_HALF;
                ask_step();
            end
        endfunction

        function void reached_edge();
            on_edge = 1'b1;
            if (op == sopc_pkg::OP_MEASURE) begin
                start_slot();
            end else begin
                start_half();
            end
        endfunction

        function void start_search(sopc_pkg::t_phase ph);
            phase      = ph;
            search_cnt = '0;
            if (step_lim == 16'd0) begin
                search_fail();
            end else begin
                ask_step();
            end
        endfunction

        // returns 1 when the transaction owes a result
        function bit note_input(logic [1:0] cmd, logic lvl);
            int unsigned owed;
            owed = pending.size();
            if (cmd == sopc_pkg::CMD_MEASURE || cmd == sopc_pkg::CMD_ALIGN) begin
                if (phase == sopc_pkg::PH_IDLE) begin
                    op = (cmd == sopc_pkg::CMD_MEASURE) ? sopc_pkg::OP_MEASURE
                                                        : sopc_pkg::OP_ALIGN;
                    if (on_edge) begin
                        reached_edge();
                    end else begin
                        start_search(lvl ? sopc_pkg::PH_FALL : sopc_pkg::PH_RISE);
                    end
                end
            end else if (cmd == sopc_pkg::CMD_REPORT && phase != sopc_pkg::PH_IDLE) begin
                case (phase)
                    sopc_pkg::PH_RISE: begin
                        search_cnt = search_cnt + 16'd1;
                        if (lvl) begin
                            start_search(sopc_pkg::PH_FALL);
                        end else if (search_cnt >= step_lim) begin
                            search_fail();
                        end else begin
                            ask_step();
                        end
                    end
                    sopc_pkg::PH_FALL: begin
                        search_cnt = search_cnt + 16'd1;
                        if (!lvl) begin
                            reached_edge();
                        end else if (search_cnt >= step_lim) begin
                            search_fail();
                        end else begin
                            ask_step();
                        end
                    end
                    sopc_pkg::PH_SLOT: begin
                        search_cnt = search_cnt + 16'd1;
                        rot_cnt    = rot_cnt + 16'd1;
                        if (lvl) begin
                            slot_len = rot_cnt;
                            start_rev();
                        end else if (search_cnt >= slot_lim) begin
                            on_edge = 1'b0;
                            finish_op(1'b0, sopc_pkg::ST_STUCK_LOW, 16'd0);
                        end else begin
                            ask_step();
                        end
                    end
                    sopc_pkg::PH_REV: begin
                        rot_cnt = rot_cnt + 16'd1;
                        if (!lvl) begin
                            on_edge = 1'b1;
                            finish_op(1'b0, sopc_pkg::ST_OK, rot_cnt);
                        end else begin
                            start_rev();
                        end
                    end
                    sopc_pkg::PH_HALF: begin
                        search_cnt = search_cnt + 16'd1;
                        if (search_cnt >= (slot_len >> 1)) begin
                            on_edge = 1'b0;
                            finish_op(1'b1, sopc_pkg::ST_OK, 16'd0);
                        end else begin
                            ask_step();
                        end
                    end
                    default: phase = sopc_pkg::PH_IDLE;
                endcase
            end
            return pending.size() != owed;
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(sopc_pkg::t_result got);
            sopc_pkg::t_result want;
            if (pending.size() == 0) begin
                $display("%0t: result expected none actual step %0d done %0d status %0d",
                         $time, got.step_request, got.done_res, got.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("step_request", 16'(want.step_request), 16'(got.step_request));
            compare_field("motor_stop", 16'(want.motor_stop), 16'(got.motor_stop));
            compare_field("done_res", 16'(want.done_res), 16'(got.done_res));
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("revolution_steps", want.revolution_steps, got.revolution_steps);
            compare_field("slot_steps", want.slot_steps, got.slot_steps);
        endfunction
    endclass

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_ready;
    logic [1:0]                    i_command      = sopc_pkg::CMD_MEASURE;
    logic                          i_sensor_level = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_ready    = 1'b0;
    logic                          o_step_request;
    logic                          o_motor_stop;
    logic                          o_done_res;
    logic [1:0]                    o_status;
    logic [15:0]                   o_revolution_steps;
    logic [15:0]                   o_slot_steps;
    logic                          psel           = 1'b0;
    logic                          penable        = 1'b0;
    logic                          pwrite         = 1'b0;
    logic [sopc_pkg::ADDR_W-1:0]   paddr          = '0;
    logic [sopc_pkg::DATA_W-1:0]   pwdata         = '0;
    logic [sopc_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    calib_scoreboard sb = new;
    bit              idle_on          = 1'b1;
    bit              hold_off_request = 1'b0;

    // hand-picked walk through every finish status plus a half-slot align, limits 3 and 2
    logic [1:0] directed_cmd [DIRECTED_N] = '{
        sopc_pkg::CMD_REPORT, CMD_UNUSED, sopc_pkg::CMD_MEASURE, sopc_pkg::CMD_MEASURE,
        sopc_pkg::CMD_REPORT, sopc_pkg::CMD_REPORT, sopc_pkg::CMD_REPORT,
        sopc_pkg::CMD_MEASURE, sopc_pkg::CMD_REPORT, sopc_pkg::CMD_REPORT,
        sopc_pkg::CMD_REPORT, sopc_pkg::CMD_REPORT, sopc_pkg::CMD_MEASURE,
        sopc_pkg::CMD_REPORT, sopc_pkg::CMD_REPORT, sopc_pkg::CMD_REPORT,
        sopc_pkg::CMD_REPORT, sopc_pkg::CMD_REPORT, sopc_pkg::CMD_MEASURE,
        sopc_pkg::CMD_REPORT, sopc_pkg::CMD_REPORT, sopc_pkg::CMD_REPORT,
        sopc_pkg::CMD_REPORT, sopc_pkg::CMD_ALIGN, sopc_pkg::CMD_REPORT
    };
    logic directed_lvl [DIRECTED_N] = '{
        1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
        1'b0, 1'b1, 1'b0, 1'b1, 1'b1
    };

    logic [15:0] step_settings [NUM_SETTINGS] = '{
        16'd1, 16'd65535, 16'd0, 16'd7, 16'd4, 16'd12, 16'd2, 16'd16, 16'd100, 16'd5
    };
    logic [15:0] slot_settings [NUM_SETTINGS] = '{
        16'd1, 16'd65535, 16'd5, 16'd0, 16'd3, 16'd6, 16'd9, 16'd16, 16'd40, 16'd65535
    };

    stepper_opto_calibration DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (i_command),
        .i_sensor_level     (i_sensor_level),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_step_request     (o_step_request),
        .o_motor_stop       (o_motor_stop),
        .o_done_res         (o_done_res),
        .o_status           (o_status),
        .o_revolution_steps (o_revolution_steps),
        .o_slot_steps       (o_slot_steps),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic write_reg(input logic idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_limit(idx, val);
    endtask

    // offers one transaction and waits until the block takes it
    task automatic offer(input logic [1:0] cmd, input logic lvl, output bit made);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_sensor_level <= lvl;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        made = sb.note_input(cmd, lvl);
    endtask

    // ignored transactions may still sit in the input register
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    initial begin : stimulus
        bit          made;
        bit          tight;
        int unsigned useful;
        int unsigned high_pct;
        int unsigned roll;
        logic [1:0]  cmd;
        logic        lvl;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(sopc_pkg::REG_STEP_LIMIT, 16'd3);
        write_reg(sopc_pkg::REG_SLOT_LIMIT, 16'd2);
        for (int i = 0; i < DIRECTED_N; i++) begin
            offer(directed_cmd[i], directed_lvl[i], made);
        end
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            settle();
            write_reg(sopc_pkg::REG_STEP_LIMIT, step_settings[p]);
            write_reg(sopc_pkg::REG_SLOT_LIMIT, slot_settings[p]);
            idle_on = (p != NUM_SETTINGS - 1) && (p % 3 != 2);
            if (p == 3) begin
                hold_off_request = 1'b1;
            end
            // fixed levels only where the limits keep the loops short
            tight    = step_settings[p] <= 16'd128 && slot_settings[p] <= 16'd128;
            useful   = 0;
            high_pct = 50;
            while (useful < ITEMS_PER_SETTING) begin
                roll = $urandom_range(0, 99);
                lvl  = 1'($urandom_range(0, 1));
                if (!sb.busy()) begin
                    if (roll < 5) begin
                        cmd = sopc_pkg::CMD_REPORT;
                    end else if (roll < 8) begin
                        cmd = CMD_UNUSED;
                    end else begin
                        cmd = roll[0] ? sopc_pkg::CMD_ALIGN : sopc_pkg::CMD_MEASURE;
                        if (tight) begin
                            case ($urandom_range(0, 4))
                                0:       high_pct = 0;
                                1:       high_pct = 10;
                                2:       high_pct = 50;
                                3:       high_pct = 90;
                                default: high_pct = 100;
                            endcase
                        end else begin
                            high_pct = $urandom_range(20, 80);
                        end
                    end
                end else begin
                    if (roll < 3) begin
                        cmd = roll[0] ? sopc_pkg::CMD_ALIGN : sopc_pkg::CMD_MEASURE;
                    end else if (roll < 5) begin
                        cmd = CMD_UNUSED;
                    end else begin
                        cmd = sopc_pkg::CMD_REPORT;
                        lvl = $urandom_range(0, 99) < high_pct;
                    end
                end
                offer(cmd, lvl, made);
                if (made) begin
                    useful++;
                end
            end
        end
        settle();
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : result_sink
        int unsigned       stall_left;
        sopc_pkg::t_result got;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.step_request     = o_step_request;
                got.motor_stop       = o_motor_stop;
                got.done_res         = o_done_res;
                got.status           = sopc_pkg::t_status'(o_status);
                got.revolution_steps = o_revolution_steps;
                got.slot_steps       = o_slot_steps;
                sb.check_result(got);
            end
            // a long hold-off lets the block fill up and push back on its input
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                stall_left       = HOLD_OFF_CYCLES;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 12);
            end
            if (stall_left != 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule
